>>> design/coord_keyed_linear_probe_table_defines.svh
// Assertion macros shared by the coordinate-keyed probe table modules
`ifndef COORD_KEYED_LINEAR_PROBE_TABLE_DEFINES_SVH
`define COORD_KEYED_LINEAR_PROBE_TABLE_DEFINES_SVH

// same-cycle implication
`define CKLPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CKLPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/cklpt_pkg.sv
// Shared types, constants and hash function of the coordinate-keyed probe table
`timescale 1ns / 1ps
package cklpt_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 256;
    localparam int unsigned KEY_W     = 48;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned LIMIT_W   = 9;
    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 9'd192;
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B9;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_SET    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR_STEP,
        OP_CAPTURE,
        OP_HASH,
        OP_HOME,
        OP_NEXT,
        OP_INSERT,
        OP_REFUSE,
        OP_HIT_LOOKUP,
        OP_HIT_SET,
        OP_HIT_CLEAR,
        OP_WALK_SEL,
        OP_TAKE,
        OP_PLACE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       rd_valid;
        logic       rd_match;
        logic       probe_last;
        logic       walk_last;
        logic       clr_last;
        logic       at_limit;
    } dp_stat_t;

    function automatic logic [31:0] hash_mix(input logic [KEY_W-1:0] k);
        logic [31:0] x;
        logic [31:0] sh;
        x  = {16'd0, k[47:32]};
        sh = {15'd0, k[23:8], 1'b0} | {7'd0, k[31:24], 17'd0} | {k[6:0], 25'd0};
        return x ^ sh;
    endfunction

endpackage

>>> design/cklpt_dp.sv
// Datapath of the probe table: key and value stores, hash, pointers and counters
`timescale 1ns / 1ps
`include "coord_keyed_linear_probe_table_defines.svh"
module cklpt_dp #(
    parameter int unsigned TABLE_DEPTH = cklpt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [8:0]           cfg_wr_data,
    input  logic [1:0]           func,
    input  logic signed [15:0]   pos_x,
    input  logic [7:0]           pos_y,
    input  logic signed [15:0]   pos_z,
    input  logic [7:0]           world_id,
    input  logic [15:0]          block_in,
    input  logic [15:0]          state_in,
    input  cklpt_pkg::ctrl_cmd_t cmd,
    output cklpt_pkg::dp_stat_t  stat,
    output logic                 found,
    output logic [15:0]          state_out,
    output logic [15:0]          block_out,
    output logic                 status
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > cklpt_pkg::LIMIT_W) ? CNT_W : cklpt_pkg::LIMIT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic [cklpt_pkg::KEY_W:0]   key_mem [TABLE_DEPTH];
    logic [cklpt_pkg::VAL_W-1:0] val_mem [TABLE_DEPTH];

    logic [cklpt_pkg::KEY_W:0]   rd_key_reg;
    logic [cklpt_pkg::VAL_W-1:0] rd_val_reg;

    logic [cklpt_pkg::LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   probe_n_reg, probe_n_next;
    logic [IDX_W-1:0]   wptr_reg, wptr_next;
    logic [IDX_W-1:0]   walk_n_reg, walk_n_next;
    logic [1:0]         func_reg, func_next;
    logic [cklpt_pkg::KEY_W-1:0] key_reg, key_next;
    logic [cklpt_pkg::VAL_W-1:0] val_reg, val_next;
    logic [cklpt_pkg::KEY_W-1:0] mkey_reg, mkey_next;
    logic [cklpt_pkg::VAL_W-1:0] mval_reg, mval_next;
    logic               src_moved_reg, src_moved_next;
    logic [31:0]        prod_reg, prod_next;
    logic               found_reg, found_next;
    logic               status_reg, status_next;
    logic [cklpt_pkg::VAL_W-1:0] hold_reg, hold_next;

    logic               found_out_reg, status_out_reg;
    logic [15:0]        state_out_reg, block_out_reg;

    logic                        kwr_en, vwr_en;
    logic [cklpt_pkg::KEY_W:0]   kwr_data;
    logic [cklpt_pkg::VAL_W-1:0] vwr_data;
    logic [31:0]                 folded;

    assign folded = prod_reg ^ (prod_reg >> 16);

    assign stat.func       = func_reg;
    assign stat.rd_valid   = rd_key_reg[cklpt_pkg::KEY_W];
    assign stat.rd_match   = rd_key_reg[cklpt_pkg::KEY_W]
                             && (rd_key_reg[cklpt_pkg::KEY_W-1:0] == key_reg);
    assign stat.probe_last = (probe_n_reg == LAST_IDX);
    assign stat.walk_last  = (walk_n_reg == LAST_IDX);
    assign stat.clr_last   = (ptr_reg == LAST_IDX);
    assign stat.at_limit   = (CMP_W'(count_reg) >= CMP_W'(limit_reg));

    always_comb
    begin
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        probe_n_next   = probe_n_reg;
        wptr_next      = wptr_reg;
        walk_n_next    = walk_n_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        mkey_next      = mkey_reg;
        mval_next      = mval_reg;
        src_moved_next = src_moved_reg;
        prod_next      = prod_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        hold_next      = hold_reg;
        kwr_en         = 1'b0;
        vwr_en         = 1'b0;
        kwr_data       = '0;
        vwr_data       = val_reg;
        unique case (cmd.op)
            cklpt_pkg::OP_NONE:
            begin
            end
            cklpt_pkg::OP_CLR_STEP:
            begin
                kwr_en   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            cklpt_pkg::OP_CAPTURE:
            begin
                func_next      = func;
                key_next       = {pos_x, pos_y, pos_z, world_id};
                val_next       = {block_in, state_in};
                src_moved_next = 1'b0;
                found_next     = 1'b0;
                status_next    = 1'b0;
                hold_next      = '0;
            end
            cklpt_pkg::OP_HASH:
            begin
                prod_next = cklpt_pkg::hash_mix(src_moved_reg ? mkey_reg : key_reg)
                            * cklpt_pkg::HASH_MULT;
            end
            cklpt_pkg::OP_HOME:
            begin
                ptr_next     = folded[IDX_W-1:0];
                probe_n_next = '0;
            end
            cklpt_pkg::OP_NEXT:
            begin
                ptr_next     = ptr_reg + 1'b1;
                probe_n_next = probe_n_reg + 1'b1;
            end
            cklpt_pkg::OP_INSERT:
            begin
                kwr_en     = 1'b1;
                kwr_data   = {1'b1, key_reg};
                vwr_en     = 1'b1;
                vwr_data   = val_reg;
                count_next = count_reg + 1'b1;
            end
            cklpt_pkg::OP_REFUSE:
            begin
                status_next = 1'b1;
            end
            cklpt_pkg::OP_HIT_LOOKUP:
            begin
                found_next = 1'b1;
                hold_next  = rd_val_reg;
            end
            cklpt_pkg::OP_HIT_SET:
            begin
                found_next = 1'b1;
                vwr_en     = 1'b1;
                vwr_data   = val_reg;
            end
            cklpt_pkg::OP_HIT_CLEAR:
            begin
                found_next  = 1'b1;
                kwr_en      = 1'b1;
                count_next  = count_reg - 1'b1;
                wptr_next   = ptr_reg + 1'b1;
                walk_n_next = '0;
            end
            cklpt_pkg::OP_WALK_SEL:
            begin
                ptr_next = wptr_reg;
            end
            cklpt_pkg::OP_TAKE:
            begin
                mkey_next      = rd_key_reg[cklpt_pkg::KEY_W-1:0];
                mval_next      = rd_val_reg;
                src_moved_next = 1'b1;
                kwr_en         = 1'b1;
            end
            cklpt_pkg::OP_PLACE:
            begin
                kwr_en      = 1'b1;
                kwr_data    = {1'b1, mkey_reg};
                vwr_en      = 1'b1;
                vwr_data    = mval_reg;
                wptr_next   = wptr_reg + 1'b1;
                walk_n_next = walk_n_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (kwr_en)
        begin
            key_mem[ptr_reg] <= kwr_data;
        end
        if (vwr_en)
        begin
            val_mem[ptr_reg] <= vwr_data;
        end
        rd_key_reg <= key_mem[ptr_reg];
        rd_val_reg <= val_mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= cklpt_pkg::LOAD_LIMIT_RESET;
            count_reg      <= '0;
            ptr_reg        <= '0;
            probe_n_reg    <= '0;
            wptr_reg       <= '0;
            walk_n_reg     <= '0;
            func_reg       <= '0;
            src_moved_reg  <= 1'b0;
            found_reg      <= 1'b0;
            status_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            probe_n_reg   <= probe_n_next;
            wptr_reg      <= wptr_next;
            walk_n_reg    <= walk_n_next;
            func_reg      <= func_next;
            src_moved_reg <= src_moved_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        val_reg  <= val_next;
        mkey_reg <= mkey_next;
        mval_reg <= mval_next;
        prod_reg <= prod_next;
        hold_reg <= hold_next;
        if (cmd.out_load)
        begin
            found_out_reg  <= found_reg;
            status_out_reg <= status_reg;
            state_out_reg  <= hold_reg[15:0];
            block_out_reg  <= hold_reg[31:16];
        end
    end

    assign found     = found_out_reg;
    assign status    = status_out_reg;
    assign state_out = state_out_reg;
    assign block_out = block_out_reg;

    `CKLPT_ASSERT_NOW(a_count_bound, 1'b1, CNT_W'(count_reg) <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
    `CKLPT_ASSERT_NEXT(a_insert_counts, cmd.op == cklpt_pkg::OP_INSERT, count_reg == $past(count_reg) + 1'b1, "insert did not advance count")

endmodule

>>> design/cklpt_ctrl.sv
// Sequencer of the probe table: reset sweep, probe walk, cluster rehash and result hand-off
`timescale 1ns / 1ps
`include "coord_keyed_linear_probe_table_defines.svh"
module cklpt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  cklpt_pkg::dp_stat_t  stat,
    output cklpt_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_HASH, S_HOME, S_RD, S_CHK, S_WSEL, S_FIN
    } state_t;

    typedef enum logic [1:0] {
        M_FIND, M_WALK, M_PLACE
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cmd.op         = cklpt_pkg::OP_NONE;
        cmd.out_load   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = cklpt_pkg::OP_CLR_STEP;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op    = cklpt_pkg::OP_CAPTURE;
                    mode_next = M_FIND;
                    if (func == cklpt_pkg::FUNC_LOOKUP || func == cklpt_pkg::FUNC_SET
                        || func == cklpt_pkg::FUNC_CLEAR)
                    begin
                        state_next = S_HASH;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_HASH:
            begin
                cmd.op     = cklpt_pkg::OP_HASH;
                state_next = S_HOME;
            end
            S_HOME:
            begin
                cmd.op     = cklpt_pkg::OP_HOME;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                unique case (mode_reg)
                    M_FIND:
                    begin
                        if (!stat.rd_valid)
                        begin
                            if (stat.func == cklpt_pkg::FUNC_SET)
                            begin
                                cmd.op = stat.at_limit ? cklpt_pkg::OP_REFUSE
                                                       : cklpt_pkg::OP_INSERT;
                            end
                            state_next = S_FIN;
                        end
                        else if (stat.rd_match)
                        begin
                            if (stat.func == cklpt_pkg::FUNC_LOOKUP)
                            begin
                                cmd.op     = cklpt_pkg::OP_HIT_LOOKUP;
                                state_next = S_FIN;
                            end
                            else if (stat.func == cklpt_pkg::FUNC_SET)
                            begin
                                cmd.op     = cklpt_pkg::OP_HIT_SET;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                cmd.op     = cklpt_pkg::OP_HIT_CLEAR;
                                mode_next  = M_WALK;
                                state_next = S_WSEL;
                            end
                        end
                        else if (stat.probe_last)
                        begin
                            if (stat.func == cklpt_pkg::FUNC_SET)
                            begin
                                cmd.op = cklpt_pkg::OP_REFUSE;
                            end
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.op     = cklpt_pkg::OP_NEXT;
                            state_next = S_RD;
                        end
                    end
                    M_WALK:
                    begin
                        if (!stat.rd_valid)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.op     = cklpt_pkg::OP_TAKE;
                            mode_next  = M_PLACE;
                            state_next = S_HASH;
                        end
                    end
                    M_PLACE:
                    begin
                        if (!stat.rd_valid)
                        begin
                            cmd.op    = cklpt_pkg::OP_PLACE;
                            mode_next = M_WALK;
                            state_next = stat.walk_last ? S_FIN : S_WSEL;
                        end
                        else
                        begin
                            cmd.op     = cklpt_pkg::OP_NEXT;
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_WSEL:
            begin
                cmd.op     = cklpt_pkg::OP_WALK_SEL;
                state_next = S_RD;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            mode_reg      <= M_FIND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CKLPT_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "took a second word while busy")
    `CKLPT_ASSERT_NOW(a_load_in_fin, cmd.out_load, state_reg == S_FIN, "result loaded outside finish")
    `CKLPT_ASSERT_NOW(a_no_accept_in_sweep, state_reg == S_CLR, !in_ready && !out_valid_reg, "word taken during reset sweep")
    `CKLPT_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_reg, "loaded result not shown")

endmodule

>>> design/coord_keyed_linear_probe_table.sv
// Top level of the coordinate-keyed linear-probe table
`timescale 1ns / 1ps
// After reset the block sweeps every slot of the key store, one slot a cycle, before
// in_ready first rises; configuration writes are taken throughout. TABLE_DEPTH must
// be a power of two. Each word is handled on its own: it is accepted, its key is hashed
// and turned into a home slot, each probed slot is read from the store and then compared,
// and the result is handed to the output register. A clear that hits then walks the rest
// of its cluster, taking out each entry and re-placing it by hashing its key again and
// probing from its home slot.
// The single-port key and value stores set the pace of these steps. A finished result
// waits in its output register while the next word is accepted.
module coord_keyed_linear_probe_table #(
    parameter int unsigned TABLE_DEPTH = cklpt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [8:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [15:0] pos_x,
    input  logic [7:0]         pos_y,
    input  logic signed [15:0] pos_z,
    input  logic [7:0]         world_id,
    input  logic [15:0]        block_in,
    input  logic [15:0]        state_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [15:0]        state_out,
    output logic [15:0]        block_out,
    output logic               status
);

    cklpt_pkg::ctrl_cmd_t cmd;
    cklpt_pkg::dp_stat_t  stat;

    cklpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cklpt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .func        (func),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .world_id    (world_id),
        .block_in    (block_in),
        .state_in    (state_in),
        .cmd         (cmd),
        .stat        (stat),
        .found       (found),
        .state_out   (state_out),
        .block_out   (block_out),
        .status      (status)
    );

endmodule
